### rtl/serial_console_line_editor_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial console line editor
// Shared property forms used by the editor's RTL modules.
// ----------------------------------------------------------------------------
`ifndef SERIAL_CONSOLE_LINE_EDITOR_MACROS_SVH
`define SERIAL_CONSOLE_LINE_EDITOR_MACROS_SVH

// Overlapping implication, checked on every clock edge outside reset.
`define SCLE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line editor assertion failed");

// Non-overlapping implication, with the consequent checked after the antecedent's clock edge.
`define SCLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line editor assertion failed");

`endif

### rtl/scle_pkg.sv
// ----------------------------------------------------------------------------
// Serial console line editor package
// Sizes, character codes, message table and the plan handed to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package scle_pkg;

   localparam int LINE_CAPACITY = 32;
   localparam int LINE_IDX_W    = $clog2(LINE_CAPACITY);
   localparam int LEN_W         = 6;
   localparam int PTR_W         = 6;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_ADDR_W-3:0] REG_FEEDBACK_ENABLE = 1'b0;

   localparam logic [7:0] CH_ETX  = 8'd3;
   localparam logic [7:0] CH_BS   = 8'd8;
   localparam logic [7:0] CH_LF   = 8'd10;
   localparam logic [7:0] CH_CR   = 8'd13;
   localparam logic [7:0] CH_ESC  = 8'd27;
   localparam logic [7:0] CH_SP   = 8'd32;
   localparam logic [7:0] CH_UP   = 8'd65;
   localparam logic [7:0] CH_DOWN = 8'd66;
   localparam logic [7:0] CH_LBR  = 8'd91;
   localparam logic [7:0] CH_DEL  = 8'd127;

   localparam int MSG_ROM_DEPTH = 34;
   localparam logic [MSG_ROM_DEPTH*8-1:0] MSG_ROM = {
      "RX BUFFER FULL", CH_CR, CH_LF,
      "*BREAK*", CH_CR, CH_LF, "> ",
      CH_BS, CH_SP, CH_BS,
      CH_ESC, "M", CH_ESC, "D"};

   localparam logic [PTR_W-1:0] MSG_FULL_FIRST   = 6'd0;
   localparam logic [PTR_W-1:0] MSG_FULL_LAST    = 6'd15;
   localparam logic [PTR_W-1:0] MSG_BREAK_FIRST  = 6'd16;
   localparam logic [PTR_W-1:0] MSG_CRLF_FIRST   = 6'd23;
   localparam logic [PTR_W-1:0] MSG_CRLF_LAST    = 6'd24;
   localparam logic [PTR_W-1:0] MSG_PROMPT_FIRST = 6'd25;
   localparam logic [PTR_W-1:0] MSG_PROMPT_LAST  = 6'd26;
   localparam logic [PTR_W-1:0] MSG_ERASE_FIRST  = 6'd27;
   localparam logic [PTR_W-1:0] MSG_ERASE_LAST   = 6'd29;
   localparam logic [PTR_W-1:0] MSG_UP_FIRST     = 6'd30;
   localparam logic [PTR_W-1:0] MSG_UP_LAST      = 6'd31;
   localparam logic [PTR_W-1:0] MSG_DOWN_FIRST   = 6'd32;
   localparam logic [PTR_W-1:0] MSG_DOWN_LAST    = 6'd33;

   typedef struct packed {
      logic [PTR_W-1:0] pre_first;
      logic [PTR_W-1:0] pre_last;
      logic [PTR_W-1:0] post_first;
      logic [PTR_W-1:0] post_last;
      logic [LEN_W-1:0] line_len;
      logic             has_line;
      logic             has_post;
      logic             is_cr;
      logic             is_brk;
      logic             use_byte;
      logic [7:0]       echo_byte;
   } plan_type;

   function automatic logic [7:0] msg_char(input logic [PTR_W-1:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (int'(idx) < MSG_ROM_DEPTH) begin
         ch = MSG_ROM[(MSG_ROM_DEPTH - 1 - int'(idx)) * 8 +: 8];
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

### rtl/serial_console_line_editor.sv
// ----------------------------------------------------------------------------
// Serial console line editor
// Edits a terminal command line one received byte at a time and produces
// echo, command and break results through a shared sequencer.
//
//   Channel   Direction  Handshake               Contents
//   req       in         req_valid / req_ready   rx_byte, command_running
//   rsp       out        rsp_valid / rsp_ready   tx, cmd, cmd_end, break, last
//   csr       in/out     psel / penable          feedback_enable at address 0
//
// A byte is taken while req_ready is high, then its results follow one per cycle while rsp_ready holds.
// A byte with results keeps req_ready low from the transfer until its last result is loaded;
// a completed line of n bytes gives n+6 results with feedback on, n+4 off.
// The sequencer's single pointer and end compare set this pace.
// A stalled rsp transfer holds the sequencer without losing results.
// Reset clears the line length and escape flags and sets feedback_enable to one;
// the line store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_console_line_editor (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_rx_byte,
   input  wire logic                              req_command_running,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_tx_byte,
   output logic                                   rsp_tx_valid,
   output logic [7:0]                             rsp_cmd_byte,
   output logic                                   rsp_cmd_valid,
   output logic                                   rsp_cmd_end,
   output logic                                   rsp_break_request,
   output logic                                   rsp_last,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [scle_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [scle_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [scle_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);

   logic [scle_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                        escape_ff, escape_in;
   logic                        bracket_ff, bracket_in;
   logic                        feedback_ff, feedback_in;

   logic                        accept;
   logic                        esc_keep;
   logic                        brk_keep;
   logic                        line_full;
   logic                        start;
   scle_pkg::plan_type          plan;
   logic                        wr_en;
   logic                        seq_idle;
   logic [scle_pkg::LINE_IDX_W-1:0] rd_addr;
   logic [7:0]                  rd_data;
   logic                        csr_write;
   logic                        csr_hit;

   assign accept    = req_valid && req_ready;
   assign req_ready = seq_idle;

   always_comb begin
      esc_keep  = escape_ff && (bracket_ff ?
                  (req_rx_byte == scle_pkg::CH_UP || req_rx_byte == scle_pkg::CH_DOWN) :
                  (req_rx_byte == scle_pkg::CH_LBR));
      brk_keep  = esc_keep && bracket_ff;
      line_full = (len_ff >= scle_pkg::LEN_W'(scle_pkg::LINE_CAPACITY - 1));

      len_in     = len_ff;
      escape_in  = escape_ff;
      bracket_in = bracket_ff;
      start      = 1'b0;
      wr_en      = 1'b0;
      plan       = '0;
      plan.line_len  = len_ff;
      plan.echo_byte = req_rx_byte;

      if (accept) begin
         escape_in  = esc_keep;
         bracket_in = brk_keep;
         if (line_full && req_rx_byte != scle_pkg::CH_DEL) begin
            start          = 1'b1;
            plan.pre_first = scle_pkg::MSG_FULL_FIRST;
            plan.pre_last  = scle_pkg::MSG_FULL_LAST;
         end else if (req_rx_byte == scle_pkg::CH_CR) begin
            start           = 1'b1;
            plan.pre_first  = scle_pkg::MSG_CRLF_FIRST;
            plan.pre_last   = scle_pkg::MSG_CRLF_LAST;
            plan.has_line   = (len_ff != '0);
            plan.has_post   = 1'b1;
            plan.post_first = feedback_ff ? scle_pkg::MSG_CRLF_FIRST :
                                            scle_pkg::MSG_PROMPT_FIRST;
            plan.post_last  = scle_pkg::MSG_PROMPT_LAST;
            plan.is_cr      = 1'b1;
            len_in          = '0;
         end else if (req_rx_byte == scle_pkg::CH_DEL) begin
            if (len_ff != '0) begin
               start          = 1'b1;
               plan.pre_first = scle_pkg::MSG_ERASE_FIRST;
               plan.pre_last  = scle_pkg::MSG_ERASE_LAST;
               len_in         = len_ff - 1'b1;
            end
         end else if (req_rx_byte == scle_pkg::CH_ETX) begin
            if (req_command_running) begin
               start          = 1'b1;
               plan.pre_first = scle_pkg::MSG_BREAK_FIRST;
               plan.pre_last  = scle_pkg::MSG_PROMPT_LAST;
               plan.is_brk    = 1'b1;
            end
         end else if (req_rx_byte == scle_pkg::CH_ESC) begin
            escape_in = 1'b1;
         end else if (esc_keep && req_rx_byte == scle_pkg::CH_LBR) begin
            bracket_in = 1'b1;
         end else if (brk_keep) begin
            start      = 1'b1;
            escape_in  = 1'b0;
            bracket_in = 1'b0;
            if (req_rx_byte == scle_pkg::CH_UP) begin
               plan.pre_first = scle_pkg::MSG_UP_FIRST;
               plan.pre_last  = scle_pkg::MSG_UP_LAST;
            end else begin
               plan.pre_first = scle_pkg::MSG_DOWN_FIRST;
               plan.pre_last  = scle_pkg::MSG_DOWN_LAST;
            end
         end else begin
            start         = 1'b1;
            wr_en         = 1'b1;
            plan.use_byte = 1'b1;
            len_in        = len_ff + 1'b1;
         end
      end
   end

   assign csr_hit     = (paddr[scle_pkg::CSR_ADDR_W-1:2] == scle_pkg::REG_FEEDBACK_ENABLE);
   assign csr_write   = psel && penable && pwrite && pready && csr_hit;
   assign feedback_in = csr_write ? pwdata[0] : feedback_ff;
   assign pready      = 1'b1;
   assign prdata      = csr_hit ? scle_pkg::CSR_DATA_W'(feedback_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         escape_ff   <= 1'b0;
         bracket_ff  <= 1'b0;
         feedback_ff <= 1'b1;
      end else begin
         len_ff      <= len_in;
         escape_ff   <= escape_in;
         bracket_ff  <= bracket_in;
         feedback_ff <= feedback_in;
      end
   end

   scle_line_ram u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[scle_pkg::LINE_IDX_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   scle_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .plan              (plan),
      .feedback_enable   (feedback_ff),
      .idle              (seq_idle),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_cmd_byte      (rsp_cmd_byte),
      .rsp_cmd_valid     (rsp_cmd_valid),
      .rsp_cmd_end       (rsp_cmd_end),
      .rsp_break_request (rsp_break_request),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/scle_line_ram.sv
// ----------------------------------------------------------------------------
// Line store
// One write port and one registered read port holding the command line.
// ----------------------------------------------------------------------------
`default_nettype none

module scle_line_ram (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [scle_pkg::LINE_IDX_W-1:0]  wr_addr,
   input  wire logic [7:0]                       wr_data,
   input  wire logic [scle_pkg::LINE_IDX_W-1:0]  rd_addr,
   output logic [7:0]                            rd_data
);

   logic [7:0] line_mem_ff [scle_pkg::LINE_CAPACITY];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= line_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/scle_seq.sv
// ----------------------------------------------------------------------------
// Result sequencer
// Steps one pointer through message text and the line store, one result per
// transfer, under a small state machine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_console_line_editor_macros.svh"

module scle_seq (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire scle_pkg::plan_type               plan,
   input  wire logic                             feedback_enable,
   output logic                                  idle,
   output logic [scle_pkg::LINE_IDX_W-1:0]       rd_addr,
   input  wire logic [7:0]                       rd_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [7:0]                            rsp_tx_byte,
   output logic                                  rsp_tx_valid,
   output logic [7:0]                            rsp_cmd_byte,
   output logic                                  rsp_cmd_valid,
   output logic                                  rsp_cmd_end,
   output logic                                  rsp_break_request,
   output logic                                  rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PRE  = 4'b0010,
      ST_LINE = 4'b0100,
      ST_POST = 4'b1000
   } seq_state_type;

   seq_state_type                 state_ff, state_in;
   logic [scle_pkg::PTR_W-1:0]    ptr_ff, ptr_in;
   logic [scle_pkg::PTR_W-1:0]    end_ff, end_in;
   scle_pkg::plan_type            plan_ff, plan_in;
   logic                          first_ff, first_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    tx_byte_ff, tx_byte_in;
   logic                          tx_valid_ff, tx_valid_in;
   logic [7:0]                    cmd_byte_ff, cmd_byte_in;
   logic                          cmd_valid_ff, cmd_valid_in;
   logic                          cmd_end_ff, cmd_end_in;
   logic                          brk_ff, brk_in;
   logic                          last_ff, last_in;

   logic                          load_en;
   logic                          load;
   logic                          step_done;
   logic [scle_pkg::PTR_W-1:0]    ptr_inc;
   logic [7:0]                    rom_char;

   always_comb begin
      load_en   = !rsp_valid_ff || rsp_ready;
      step_done = (ptr_ff == end_ff);
      ptr_inc   = ptr_ff + 1'b1;
      rom_char  = scle_pkg::msg_char(ptr_ff);

      state_in    = state_ff;
      ptr_in      = ptr_ff;
      end_in      = end_ff;
      plan_in     = plan_ff;
      first_in    = first_ff;
      load        = 1'b0;
      tx_byte_in  = tx_byte_ff;
      tx_valid_in = tx_valid_ff;
      cmd_byte_in = cmd_byte_ff;
      cmd_valid_in = cmd_valid_ff;
      cmd_end_in  = cmd_end_ff;
      brk_in      = brk_ff;
      last_in     = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               plan_in  = plan;
               state_in = ST_PRE;
               ptr_in   = plan.pre_first;
               end_in   = plan.pre_last;
               first_in = 1'b1;
            end
         end
         ST_PRE: begin
            if (load_en) begin
               load         = 1'b1;
               tx_byte_in   = plan_ff.use_byte ? plan_ff.echo_byte : rom_char;
               tx_valid_in  = 1'b1;
               cmd_byte_in  = 8'h00;
               cmd_valid_in = 1'b0;
               cmd_end_in   = 1'b0;
               brk_in       = first_ff && plan_ff.is_brk;
               last_in      = 1'b0;
               first_in     = 1'b0;
               if (step_done) begin
                  if (plan_ff.has_line) begin
                     state_in = ST_LINE;
                     ptr_in   = '0;
                     end_in   = scle_pkg::PTR_W'(plan_ff.line_len - 1'b1);
                  end else if (plan_ff.has_post) begin
                     state_in = ST_POST;
                     ptr_in   = plan_ff.post_first;
                     end_in   = plan_ff.post_last;
                     first_in = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                     last_in  = 1'b1;
                  end
               end else begin
                  ptr_in = ptr_inc;
               end
            end
         end
         ST_LINE: begin
            if (load_en) begin
               load         = 1'b1;
               tx_byte_in   = rd_data;
               tx_valid_in  = feedback_enable;
               cmd_byte_in  = rd_data;
               cmd_valid_in = 1'b1;
               cmd_end_in   = 1'b0;
               brk_in       = 1'b0;
               last_in      = 1'b0;
               if (step_done) begin
                  state_in = ST_POST;
                  ptr_in   = plan_ff.post_first;
                  end_in   = plan_ff.post_last;
                  first_in = 1'b1;
               end else begin
                  ptr_in = ptr_inc;
               end
            end
         end
         ST_POST: begin
            if (load_en) begin
               load         = 1'b1;
               tx_byte_in   = rom_char;
               tx_valid_in  = 1'b1;
               cmd_byte_in  = 8'h00;
               cmd_valid_in = 1'b0;
               cmd_end_in   = first_ff && plan_ff.is_cr;
               brk_in       = 1'b0;
               last_in      = step_done;
               first_in     = 1'b0;
               if (step_done) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_inc;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      plan_ff      <= plan_in;
      first_ff     <= first_in;
      tx_byte_ff   <= tx_byte_in;
      tx_valid_ff  <= tx_valid_in;
      cmd_byte_ff  <= cmd_byte_in;
      cmd_valid_ff <= cmd_valid_in;
      cmd_end_ff   <= cmd_end_in;
      brk_ff       <= brk_in;
      last_ff      <= last_in;
   end

   assign idle              = (state_ff == ST_IDLE);
   assign rd_addr           = ptr_in[scle_pkg::LINE_IDX_W-1:0];
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_byte       = tx_byte_ff;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_cmd_byte      = cmd_byte_ff;
   assign rsp_cmd_valid     = cmd_valid_ff;
   assign rsp_cmd_end       = cmd_end_ff;
   assign rsp_break_request = brk_ff;
   assign rsp_last          = last_ff;

   `SCLE_ASSERT_IMP(a_start_only_idle, clock, reset, start, state_ff == ST_IDLE)
   `SCLE_ASSERT_IMP(a_ptr_within_end, clock, reset, state_ff != ST_IDLE, ptr_ff <= end_ff)
   `SCLE_ASSERT_NEXT(a_last_returns_idle, clock, reset, load && last_in, state_ff == ST_IDLE)

endmodule

`default_nettype wire

### verif/serial_console_line_editor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial console line editor testbench
// Sends terminal bytes through the req channel and checks every rsp transfer
// against a line editing model kept in the testbench. A directed opening
// covers erase, break, arrow keys, broken escapes and a full line; random
// phases then follow under both feedback settings, with random idling on
// both channels.
// ----------------------------------------------------------------------------

module serial_console_line_editor_tb;

   localparam int  SETTLE_CYCLES = 8;
   localparam int  DRAIN_LIMIT   = 4000;
   localparam int  PHASE_ITEMS   = 12;
   localparam int  RANDOM_PHASES = 6;
   localparam real TIMEOUT_NS    = 10_000_000.0;

   localparam logic [7:0] CH_M = 8'h4D;
   localparam logic [7:0] CH_D = 8'h44;
   localparam logic [scle_pkg::CSR_ADDR_W-1:0] FEEDBACK_ADDR =
      {scle_pkg::REG_FEEDBACK_ENABLE, 2'b00};

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       running;
      logic       drain;
   } rx_item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic [7:0] cmd_byte;
      logic       cmd_valid;
      logic       cmd_end;
      logic       break_request;
      logic       last;
   } editor_out_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_rx_byte = 8'h00;
   logic                            req_command_running = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [7:0]                      rsp_tx_byte;
   logic                            rsp_tx_valid;
   logic [7:0]                      rsp_cmd_byte;
   logic                            rsp_cmd_valid;
   logic                            rsp_cmd_end;
   logic                            rsp_break_request;
   logic                            rsp_last;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [scle_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [scle_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [scle_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   rx_item_type    rx_pending[$];
   editor_out_type editor_out_q[$];
   editor_out_type step_out[$];

   logic [7:0] model_line [scle_pkg::LINE_CAPACITY];
   logic [5:0] model_len;
   logic       model_esc;
   logic       model_lbr;
   logic       feedback_on;

   string full_msg   = "RX BUFFER FULL";
   string break_msg  = "*BREAK*";
   string prompt_msg = "> ";

   int  mismatch_count = 0;
   int  rsp_count = 0;
   int  queued_count = 0;
   int  send_odds = 0;
   int  recv_odds = 0;
   int  send_gap = 0;
   int  recv_stall = 0;
   logic drain_next = 1'b0;

   serial_console_line_editor u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .req_command_running (req_command_running),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_cmd_byte        (rsp_cmd_byte),
      .rsp_cmd_valid       (rsp_cmd_valid),
      .rsp_cmd_end         (rsp_cmd_end),
      .rsp_break_request   (rsp_break_request),
      .rsp_last            (rsp_last),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   rsp_count, name, got, want));
      end
   endtask

   task automatic check_flag(input string name, input logic got, input logic want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   rsp_count, name, got, want));
      end
   endtask

   function automatic void emit_rsp(input logic [7:0] tx, input logic txv,
                                    input logic [7:0] cmd, input logic cmdv,
                                    input logic cend, input logic brk);
      step_out.push_back('{tx_byte: tx, tx_valid: txv, cmd_byte: cmd, cmd_valid: cmdv,
                           cmd_end: cend, break_request: brk, last: 1'b0});
   endfunction

   function automatic void emit_text(input string s, input int from);
      for (int i = from; i < s.len(); i++) begin
         emit_rsp(s[i], 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
      end
   endfunction

   function automatic void emit_crlf();
      emit_rsp(scle_pkg::CH_CR, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
      emit_rsp(scle_pkg::CH_LF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
   endfunction

   function automatic void predict_edit(input logic [7:0] c, input logic running);
      editor_out_type tail;
      if (model_esc && !model_lbr && c != scle_pkg::CH_LBR) begin
         model_esc = 1'b0;
         model_lbr = 1'b0;
      end
      if (model_esc && model_lbr && c != scle_pkg::CH_UP && c != scle_pkg::CH_DOWN) begin
         model_esc = 1'b0;
         model_lbr = 1'b0;
      end
      if (int'(model_len) >= scle_pkg::LINE_CAPACITY - 1 && c != scle_pkg::CH_DEL) begin
         emit_text(full_msg, 0);
         emit_crlf();
      end else if (c == scle_pkg::CH_CR) begin
         emit_crlf();
         for (int i = 0; i < int'(model_len); i++) begin
            emit_rsp(model_line[scle_pkg::LINE_IDX_W'(i)], feedback_on,
                     model_line[scle_pkg::LINE_IDX_W'(i)], 1'b1, 1'b0, 1'b0);
         end
         if (feedback_on) begin
            emit_rsp(scle_pkg::CH_CR, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0);
            emit_rsp(scle_pkg::CH_LF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
            emit_text(prompt_msg, 0);
         end else begin
            emit_rsp(prompt_msg[0], 1'b1, 8'h00, 1'b0, 1'b1, 1'b0);
            emit_text(prompt_msg, 1);
         end
         model_len = '0;
      end else if (c == scle_pkg::CH_DEL) begin
         if (model_len != '0) begin
            model_len = model_len - 1'b1;
            emit_rsp(scle_pkg::CH_BS, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
            emit_rsp(scle_pkg::CH_SP, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
            emit_rsp(scle_pkg::CH_BS, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
         end
      end else if (c == scle_pkg::CH_ETX) begin
         if (running) begin
            emit_rsp(break_msg[0], 1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
            emit_text(break_msg, 1);
            emit_crlf();
            emit_text(prompt_msg, 0);
         end
      end else if (c == scle_pkg::CH_ESC) begin
         model_esc = 1'b1;
      end else if (model_esc && c == scle_pkg::CH_LBR) begin
         model_lbr = 1'b1;
      end else if (model_esc && model_lbr) begin
         emit_rsp(scle_pkg::CH_ESC, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
         emit_rsp((c == scle_pkg::CH_UP) ? CH_M : CH_D, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
         model_esc = 1'b0;
         model_lbr = 1'b0;
      end else begin
         if (int'(model_len) < scle_pkg::LINE_CAPACITY) begin
            model_line[model_len[scle_pkg::LINE_IDX_W-1:0]] = c;
         end
         model_len = model_len + 1'b1;
         emit_rsp(c, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
      end
      if (step_out.size() != 0) begin
         tail = step_out.pop_back();
         tail.last = 1'b1;
         step_out.push_back(tail);
      end
      foreach (step_out[i]) begin
         editor_out_q.push_back(step_out[i]);
      end
      step_out.delete();
   endfunction

   // Request driver.
   always @(posedge clock) begin
      logic        offer;
      rx_item_type nxt;
      offer = req_valid;
      if (reset) begin
         offer = 1'b0;
         send_gap = 0;
         model_len = '0;
         model_esc = 1'b0;
         model_lbr = 1'b0;
         feedback_on = 1'b1;
      end else begin
         if (req_valid && req_ready) begin
            predict_edit(req_rx_byte, req_command_running);
            offer = 1'b0;
            if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
               send_gap = $urandom_range(1, 12);
            end
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (rx_pending.size() != 0 &&
                         !(rx_pending[0].drain && editor_out_q.size() != 0)) begin
               nxt = rx_pending.pop_front();
               offer = 1'b1;
               req_rx_byte <= nxt.rx_byte;
               req_command_running <= nxt.running;
            end
         end
      end
      req_valid <= offer;
   end

   // Result monitor.
   always @(posedge clock) begin
      logic           take;
      editor_out_type want;
      take = rsp_ready;
      if (reset) begin
         take = 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (editor_out_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result, tx_byte %0d cmd_byte %0d",
                                         rsp_tx_byte, rsp_cmd_byte));
            end else begin
               want = editor_out_q.pop_front();
               check_field("tx_byte", rsp_tx_byte, want.tx_byte);
               check_flag("tx_valid", rsp_tx_valid, want.tx_valid);
               check_field("cmd_byte", rsp_cmd_byte, want.cmd_byte);
               check_flag("cmd_valid", rsp_cmd_valid, want.cmd_valid);
               check_flag("cmd_end", rsp_cmd_end, want.cmd_end);
               check_flag("break_request", rsp_break_request, want.break_request);
               check_flag("last", rsp_last, want.last);
            end
            rsp_count++;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            take = 1'b0;
         end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
            recv_stall = $urandom_range(0, 11);
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
      end
      rsp_ready <= take;
   end

   task automatic queue_rx(input logic [7:0] b, input logic run);
      rx_pending.push_back('{rx_byte: b, running: run, drain: drain_next});
      drain_next = 1'b0;
      queued_count++;
   endtask

   function automatic logic [7:0] content_byte();
      if ($urandom_range(0, 7) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return 8'($urandom_range(32, 126));
   endfunction

   task automatic wait_drained();
      while (rx_pending.size() != 0 || req_valid || editor_out_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_feedback(input logic enable);
      logic [scle_pkg::CSR_DATA_W-1:0] word;
      word = $urandom();
      word[0] = enable;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= FEEDBACK_ADDR;
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      feedback_on = enable;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {{(scle_pkg::CSR_DATA_W-1){1'b0}}, enable}) begin
         report_mismatch($sformatf("feedback_enable read back %0h, expected %0h",
                                   prdata, enable));
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int   start;
      int   n;
      logic fb;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_odds = 4;
      recv_odds = 4;
      queue_rx(scle_pkg::CH_CR, 1'b0);
      queue_rx(scle_pkg::CH_DEL, 1'b1);
      queue_rx("a", 1'b0);
      queue_rx(scle_pkg::CH_DEL, 1'b0);
      queue_rx(scle_pkg::CH_ETX, 1'b0);
      queue_rx(scle_pkg::CH_ETX, 1'b1);
      queue_rx(scle_pkg::CH_ESC, 1'b0);
      queue_rx(scle_pkg::CH_LBR, 1'b0);
      queue_rx(scle_pkg::CH_UP, 1'b0);
      queue_rx(scle_pkg::CH_ESC, 1'b1);
      queue_rx(scle_pkg::CH_LBR, 1'b1);
      queue_rx(scle_pkg::CH_DOWN, 1'b1);
      queue_rx(scle_pkg::CH_ESC, 1'b0);
      queue_rx("x", 1'b0);
      queue_rx(scle_pkg::CH_ESC, 1'b0);
      queue_rx(scle_pkg::CH_LBR, 1'b0);
      queue_rx("z", 1'b1);
      queue_rx(scle_pkg::CH_ESC, 1'b0);
      queue_rx(scle_pkg::CH_ESC, 1'b0);
      queue_rx(scle_pkg::CH_LBR, 1'b0);
      queue_rx(scle_pkg::CH_UP, 1'b0);
      queue_rx(8'h00, 1'b0);
      queue_rx(8'hFF, 1'b1);
      queue_rx(8'h80, 1'b1);
      queue_rx(scle_pkg::CH_CR, 1'b1);
      wait_drained();

      // Fill the line to capacity, then push against the limit.
      set_feedback(1'b0);
      send_odds = 3;
      recv_odds = 3;
      for (int i = 0; i < scle_pkg::LINE_CAPACITY - 1; i++) begin
         queue_rx(8'($urandom_range(32, 126)), 1'($urandom_range(0, 1)));
      end
      queue_rx("q", 1'b0);
      queue_rx(scle_pkg::CH_DEL, 1'b0);
      queue_rx("r", 1'b1);
      queue_rx(scle_pkg::CH_ESC, 1'b0);
      queue_rx(scle_pkg::CH_LBR, 1'b0);
      queue_rx(scle_pkg::CH_CR, 1'b0);
      queue_rx(scle_pkg::CH_DEL, 1'b1);
      queue_rx(scle_pkg::CH_DEL, 1'b0);
      queue_rx(scle_pkg::CH_CR, 1'b0);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         fb = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
         if (phase == RANDOM_PHASES - 2) begin
            fb = ~feedback_on;
         end
         set_feedback(fb);
         if (phase == RANDOM_PHASES - 1) begin
            send_odds = 0;
            recv_odds = 0;
         end else begin
            send_odds = 4 * $urandom_range(0, 2);
            recv_odds = 4 * $urandom_range(0, 2);
         end
         start = queued_count;
         while (queued_count - start < PHASE_ITEMS) begin
            if (phase == 1 && queued_count - start >= PHASE_ITEMS / 2 &&
                queued_count - start < PHASE_ITEMS / 2 + 3) begin
               drain_next = 1'b1;
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  n = $urandom_range(1, 8);
                  for (int i = 0; i < n; i++) begin
                     queue_rx(content_byte(), 1'($urandom_range(0, 1)));
                  end
                  if ($urandom_range(0, 2) == 0) begin
                     queue_rx(scle_pkg::CH_DEL, 1'($urandom_range(0, 1)));
                  end
                  queue_rx(scle_pkg::CH_CR, 1'($urandom_range(0, 1)));
               end
               4: begin
                  queue_rx(scle_pkg::CH_ESC, 1'($urandom_range(0, 1)));
                  queue_rx(scle_pkg::CH_LBR, 1'($urandom_range(0, 1)));
                  queue_rx($urandom_range(0, 1) ? scle_pkg::CH_UP : scle_pkg::CH_DOWN,
                           1'($urandom_range(0, 1)));
               end
               5: begin
                  queue_rx(scle_pkg::CH_ETX, 1'($urandom_range(0, 1)));
               end
               6: begin
                  queue_rx(scle_pkg::CH_ESC, 1'($urandom_range(0, 1)));
                  if ($urandom_range(0, 1) == 0) begin
                     queue_rx(scle_pkg::CH_LBR, 1'($urandom_range(0, 1)));
                  end
                  queue_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
               7: begin
                  if ($urandom_range(0, 3) == 0) begin
                     n = $urandom_range(scle_pkg::LINE_CAPACITY - 4,
                                        scle_pkg::LINE_CAPACITY + 1);
                     for (int i = 0; i < n; i++) begin
                        queue_rx(8'($urandom_range(32, 126)), 1'($urandom_range(0, 1)));
                     end
                     if ($urandom_range(0, 1) == 0) begin
                        queue_rx(scle_pkg::CH_DEL, 1'($urandom_range(0, 1)));
                     end
                     queue_rx(scle_pkg::CH_CR, 1'($urandom_range(0, 1)));
                  end else begin
                     queue_rx(scle_pkg::CH_DEL, 1'($urandom_range(0, 1)));
                  end
               end
               default: begin
                  queue_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
            endcase
         end
         if (phase != RANDOM_PHASES - 1) begin
            wait_drained();
         end
      end

      while (rx_pending.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      n = 0;
      while (editor_out_q.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (editor_out_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   editor_out_q.size()));
      end
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### serial_console_line_editor.f
+incdir+rtl
rtl/scle_pkg.sv
rtl/scle_line_ram.sv
rtl/scle_seq.sv
rtl/serial_console_line_editor.sv
verif/serial_console_line_editor_tb.sv
